### rtl/sgcj_pkg.sv
// Shared types and constants of the scatter-gather copy job merger.
package sgcj_pkg;

    localparam int DEST_DEPTH  = 16;
    localparam int MAX_JOBS    = 16;
    localparam int PTR_W       = $clog2(DEST_DEPTH);
    localparam int CNT_W       = $clog2(DEST_DEPTH + 1);
    localparam int JOB_N_W     = $clog2(MAX_JOBS);
    localparam int HDR_W       = 7;
    localparam int HDR_MAX     = 64;
    localparam int HDR_RESET   = 12;
    localparam int ADDR_W      = 64;
    localparam int LEN_W       = 16;
    localparam int REM_W       = LEN_W + 1;
    localparam int IDX_W       = 16;
    localparam int TOTAL_W     = 32;

    localparam logic OP_QUEUE = 1'b0;
    localparam logic OP_COPY  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic              end_of_descriptor;
        logic              first_of_packet;
    } sgcj_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  source_address;
        logic [ADDR_W-1:0]  dest_address;
        logic [LEN_W-1:0]   copy_length;
        logic [IDX_W-1:0]   descriptor_index;
        logic [TOTAL_W-1:0] descriptor_bytes;
        logic               overrun;
        logic               last;
    } sgcj_job_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic              end_mark;
    } sgcj_entry_t;

    typedef struct packed {
        logic queue_write;
        logic copy_start;
        logic drop_pop;
        logic job_fire;
    } sgcj_cmd_t;

    typedef struct packed {
        logic queue_empty;
        logic head_end;
        logic desc_open;
        logic out_free;
        logic job_done;
    } sgcj_status_t;

endpackage

### rtl/sgcj_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgcj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/sgcj_ctrl.sv
// Sequencer: accepts items, walks the drop loop and issues one job per cycle while the output is free.
module sgcj_ctrl import sgcj_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  logic         item_op,
    input  logic         item_first,
    input  sgcj_status_t status,
    output sgcj_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DROP = 3'b010,
        ST_JOB  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.queue_write  = accept && (item_op == OP_QUEUE);
        cmd.copy_start   = accept && (item_op == OP_COPY);
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.copy_start)
                begin
                    state_next = (item_first && status.desc_open) ? ST_DROP : ST_JOB;
                end
            end
            ST_DROP:
            begin
                // discard buffers up to and including the end-marked one
                if (status.queue_empty)
                begin
                    state_next = ST_JOB;
                end
                else
                begin
                    cmd.drop_pop = 1'b1;
                    if (status.head_end)
                    begin
                        state_next = ST_JOB;
                    end
                end
            end
            ST_JOB:
            begin
                if (status.out_free)
                begin
                    cmd.job_fire = 1'b1;
                    if (status.job_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/sgcj_dp.sv
// Datapath: destination queue, descriptor bookkeeping, job arithmetic, output register.
module sgcj_dp import sgcj_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             header_we,
    input  logic [HDR_W-1:0] header_wdata,
    input  sgcj_item_t       item,
    input  sgcj_cmd_t        cmd,
    output sgcj_status_t     status,
    output logic             job_valid,
    input  logic             job_ready,
    output sgcj_job_t        job
);

    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LEN_W-1:0]   offset_reg, offset_next;
    logic               open_reg, open_next;
    logic [IDX_W-1:0]   counter_reg, counter_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [HDR_W-1:0]   header_reg;
    logic [ADDR_W-1:0]  src_reg, src_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [JOB_N_W-1:0] job_n_reg, job_n_next;
    logic               out_valid_reg, out_valid_next;
    sgcj_job_t          job_reg, job_next;

    sgcj_entry_t                    wr_entry;
    logic [$bits(sgcj_entry_t)-1:0] ram_rdata;
    sgcj_entry_t                    head;
    logic                           full;
    logic                           empty;
    logic                           ram_we;
    logic [LEN_W-1:0]               avail;
    logic [REM_W-1:0]               bytes_w;
    logic [LEN_W-1:0]               bytes;
    logic                           short;
    logic                           ovr;
    logic [TOTAL_W:0]               sum;
    logic [TOTAL_W-1:0]             total_new;
    logic [LEN_W-1:0]               offset_new;
    logic [HDR_W-1:0]               hdr_sel;

    assign full   = (count_reg == CNT_W'(DEST_DEPTH));
    assign empty  = (count_reg == '0);
    assign ram_we = cmd.queue_write && !full;

    assign wr_entry.addr     = item.address;
    assign wr_entry.len      = item.length;
    assign wr_entry.end_mark = item.end_of_descriptor;

    // read the head that will be current next cycle
    sgcj_ram #(
        .WIDTH ($bits(sgcj_entry_t)),
        .DEPTH (DEST_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (wr_entry),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    assign head = sgcj_entry_t'(ram_rdata);

    always_comb
    begin
        avail      = (head.len > offset_reg) ? (head.len - offset_reg) : '0;
        bytes_w    = ({1'b0, avail} < rem_reg) ? {1'b0, avail} : rem_reg;
        bytes      = bytes_w[LEN_W-1:0];
        short      = (bytes_w != rem_reg);
        ovr        = empty || ((job_n_reg == JOB_N_W'(MAX_JOBS - 1)) && short);
        sum        = {1'b0, (open_reg ? total_reg : '0)} + (TOTAL_W + 1)'(bytes);
        total_new  = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        offset_new = offset_reg + bytes;
        hdr_sel    = item.first_of_packet ? header_reg : '0;
    end

    assign status.queue_empty = empty;
    assign status.head_end    = head.end_mark;
    assign status.desc_open   = open_reg;
    assign status.out_free    = !out_valid_reg || job_ready;
    assign status.job_done    = ovr || !short;

    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        offset_next    = offset_reg;
        open_next      = open_reg;
        counter_next   = counter_reg;
        total_next     = total_reg;
        src_next       = src_reg;
        rem_next       = rem_reg;
        job_n_next     = job_n_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg && !job_ready;

        if (ram_we)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEST_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end

        if (cmd.copy_start)
        begin
            src_next   = item.address - ADDR_W'(hdr_sel);
            rem_next   = REM_W'(item.length) + REM_W'(hdr_sel);
            job_n_next = '0;
            if (item.first_of_packet)
            begin
                offset_next = '0;
                open_next   = 1'b0;
            end
        end

        if (cmd.drop_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEST_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
            offset_next = '0;
        end

        if (cmd.job_fire)
        begin
            out_valid_next = 1'b1;
            job_n_next     = job_n_reg + 1'b1;
            job_next.last  = 1'b1;
            job_next.source_address = src_reg;
            if (ovr)
            begin
                // no destination left or job limit reached: flag the job and consume nothing
                job_next.dest_address     = '0;
                job_next.copy_length      = rem_reg[LEN_W] ? '1 : rem_reg[LEN_W-1:0];
                job_next.descriptor_index = '0;
                job_next.descriptor_bytes = '0;
                job_next.overrun          = 1'b1;
            end
            else
            begin
                job_next.dest_address     = head.addr + ADDR_W'(offset_reg);
                job_next.copy_length      = bytes;
                job_next.descriptor_index = open_reg ? (counter_reg - 1'b1) : counter_reg;
                job_next.descriptor_bytes = total_new;
                job_next.overrun          = 1'b0;
                job_next.last             = !short;
                if (!open_reg)
                begin
                    counter_next = counter_reg + 1'b1;
                end
                total_next  = total_new;
                src_next    = src_reg + ADDR_W'(bytes);
                rem_next    = rem_reg - REM_W'(bytes);
                offset_next = offset_new;
                open_next   = 1'b1;
                if (offset_new >= head.len)
                begin
                    rd_ptr_next = (rd_ptr_reg == PTR_W'(DEST_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                    count_next  = count_reg - 1'b1;
                    offset_next = '0;
                    if (head.end_mark)
                    begin
                        open_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            offset_reg    <= '0;
            open_reg      <= 1'b0;
            counter_reg   <= '0;
            total_reg     <= '0;
            header_reg    <= HDR_W'(HDR_RESET);
            job_n_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            offset_reg    <= offset_next;
            open_reg      <= open_next;
            counter_reg   <= counter_next;
            total_reg     <= total_next;
            job_n_reg     <= job_n_next;
            out_valid_reg <= out_valid_next;
            if (header_we)
            begin
                header_reg <= (header_wdata > HDR_W'(HDR_MAX)) ? HDR_W'(HDR_MAX) : header_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        rem_reg <= rem_next;
        job_reg <= job_next;
    end

    assign job_valid = out_valid_reg;
    assign job       = job_reg;

endmodule

### rtl/scatter_gather_copy_job_merge.sv
// Top level of the scatter-gather copy job merger.
// Queue item: written to the queue (refused when full), no job. Source segment: accepted,
// then at a packet start with a descriptor open, buffers are dropped up to the end-marked
// one or until the queue runs empty, then one job per cycle while job_ready holds high;
// with no drop the first job uses the head from the queue RAM's registered read port.
// Reset (async, rst_n low) empties the queue, closes the descriptor, zeroes the counters
// and sets header_bytes to 12; queue RAM contents are not cleared.
module scatter_gather_copy_job_merge import sgcj_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    // item channel
    input  logic             item_valid,
    output logic             item_ready,
    input  sgcj_item_t       item,
    // job channel
    output logic             job_valid,
    input  logic             job_ready,
    output sgcj_job_t        job,
    // header_bytes register write
    input  logic             header_we,
    input  logic [HDR_W-1:0] header_wdata
);

    sgcj_cmd_t    cmd;
    sgcj_status_t status;

    // Sequencer: decides per cycle whether to accept, drop a buffer or fire a job.
    sgcj_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_op    (item.operation),
        .item_first (item.first_of_packet),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: queue RAM, pointers, descriptor state, job output register.
    sgcj_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .header_we    (header_we),
        .header_wdata (header_wdata),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job)
    );

endmodule

### tb/sv/sgcj_job_board_pkg.sv
// Scoreboard class: predicts copy jobs from accepted items and checks the job stream.
`timescale 1ns / 1ps
package sgcj_job_board_pkg;
    import sgcj_pkg::*;

    class sgcj_job_board;
        // predictor copy of the destination queue and descriptor state
        logic [ADDR_W-1:0] buf_addr [DEST_DEPTH];
        logic [LEN_W-1:0]  buf_len  [DEST_DEPTH];
        bit                buf_end  [DEST_DEPTH];
        logic [PTR_W-1:0]  rd_ptr;
        logic [PTR_W-1:0]  wr_ptr;
        int unsigned       queued;
        int unsigned       head_used;
        bit                desc_open;
        bit [IDX_W-1:0]    desc_count;
        bit [TOTAL_W-1:0]  desc_total;
        int unsigned       hdr_bytes;

        sgcj_job_t         pending_jobs[$];

        int unsigned       errors;
        int unsigned       n_queued;
        int unsigned       n_full_drops;
        int unsigned       n_segments;
        int unsigned       n_jobs;
        int unsigned       n_overruns;
        int unsigned       n_counted;

        function new();
            rd_ptr     = '0;
            wr_ptr     = '0;
            queued     = 0;
            head_used  = 0;
            desc_open  = 1'b0;
            desc_count = '0;
            desc_total = '0;
            hdr_bytes  = HDR_RESET;
        endfunction

        function int unsigned waiting();
            return pending_jobs.size();
        endfunction

        function void set_header(logic [HDR_W-1:0] value);
            hdr_bytes = (32'(value) > HDR_MAX) ? HDR_MAX : 32'(value);
        endfunction

        function logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
            return (p == PTR_W'(DEST_DEPTH - 1)) ? '0 : p + 1'b1;
        endfunction

        // advance past the head buffer; return its end-of-descriptor mark
        function bit pop_head();
            bit end_mark;
            end_mark  = buf_end[rd_ptr];
            rd_ptr    = next_ptr(rd_ptr);
            queued    = queued - 1;
            head_used = 0;
            return end_mark;
        endfunction

        function void note_item(sgcj_item_t it);
            int unsigned       hdr;
            int unsigned       remain;
            int unsigned       blen;
            int unsigned       avail;
            int unsigned       nbytes;
            int unsigned       n_out;
            logic [ADDR_W-1:0] src;
            bit                done;
            sgcj_job_t         j;

            n_counted++;
            if (it.operation == OP_QUEUE)
            begin
                if (queued < DEST_DEPTH)
                begin
                    buf_addr[wr_ptr] = it.address;
                    buf_len[wr_ptr]  = it.length;
                    buf_end[wr_ptr]  = it.end_of_descriptor;
                    wr_ptr = next_ptr(wr_ptr);
                    queued = queued + 1;
                    n_queued++;
                end
                else
                begin
                    n_full_drops++;
                end
                return;
            end

            n_segments++;
            hdr = 0;
            if (it.first_of_packet)
            begin
                // drop what is left of the open descriptor
                if (desc_open)
                begin
                    while (queued > 0)
                    begin
                        if (pop_head())
                            break;
                    end
                    desc_open = 1'b0;
                end
                head_used = 0;
                hdr = hdr_bytes;
            end

            remain = 32'(it.length) + hdr;
            src    = it.address - ADDR_W'(hdr);
            n_out  = 0;
            forever
            begin
                blen   = 0;
                nbytes = 0;
                if (queued > 0)
                begin
                    blen   = 32'(buf_len[rd_ptr]);
                    avail  = (blen > head_used) ? blen - head_used : 0;
                    nbytes = (avail < remain) ? avail : remain;
                end
                if (queued == 0 || (n_out == MAX_JOBS - 1 && nbytes < remain))
                begin
                    j = '0;
                    j.source_address = src;
                    j.copy_length    = (remain > 32'hFFFF) ? 16'hFFFF : remain[LEN_W-1:0];
                    j.overrun        = 1'b1;
                    j.last           = 1'b1;
                    pending_jobs.push_back(j);
                    return;
                end
                if (!desc_open)
                begin
                    desc_open  = 1'b1;
                    desc_count = desc_count + 1'b1;
                    desc_total = '0;
                    head_used  = 0;
                end
                desc_total = (desc_total > 32'hFFFF_FFFF - nbytes) ? 32'hFFFF_FFFF
                                                                   : desc_total + nbytes;
                done = (nbytes == remain);
                j.source_address   = src;
                j.dest_address     = buf_addr[rd_ptr] + ADDR_W'(head_used);
                j.copy_length      = nbytes[LEN_W-1:0];
                j.descriptor_index = desc_count - 1'b1;
                j.descriptor_bytes = desc_total;
                j.overrun          = 1'b0;
                j.last             = done;
                pending_jobs.push_back(j);
                n_out++;

                src       = src + ADDR_W'(nbytes);
                remain    = remain - nbytes;
                head_used = head_used + nbytes;
                if (head_used >= blen)
                begin
                    if (pop_head())
                        desc_open = 1'b0;
                end
                if (done)
                    return;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task compare(string name, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
            if (got !== want)
                report($sformatf("job %0d %s got %h want %h", n_jobs, name, got, want));
        endtask

        task check_job(sgcj_job_t got);
            sgcj_job_t want;
            if (pending_jobs.size() == 0)
            begin
                report($sformatf("unexpected job src %h dst %h len %0d",
                                 got.source_address, got.dest_address, got.copy_length));
                return;
            end
            want = pending_jobs.pop_front();
            n_jobs++;
            if (want.overrun)
                n_overruns++;
            compare("source_address",   got.source_address,   want.source_address);
            compare("dest_address",     got.dest_address,     want.dest_address);
            compare("copy_length",      ADDR_W'(got.copy_length),
                    ADDR_W'(want.copy_length));
            compare("descriptor_index", ADDR_W'(got.descriptor_index),
                    ADDR_W'(want.descriptor_index));
            compare("descriptor_bytes", ADDR_W'(got.descriptor_bytes),
                    ADDR_W'(want.descriptor_bytes));
            compare("overrun",          ADDR_W'(got.overrun),  ADDR_W'(want.overrun));
            compare("last",             ADDR_W'(got.last),     ADDR_W'(want.last));
        endtask
    endclass

endpackage

### tb/sv/tb.sv
// Top-level testbench of the scatter-gather copy job merger.
`timescale 1ns / 1ps
module tb;
    import sgcj_pkg::*;
    import sgcj_job_board_pkg::*;

    // Kinds of random traffic: a well-formed descriptor plus packet, a long
    // segment over many tiny buffers (job limit), a burst of buffers that
    // can fill the queue, a fully random item, and a segment with no new buffers.
    typedef enum int {
        MIX_PACKET,
        MIX_JOB_LIMIT,
        MIX_QUEUE_BURST,
        MIX_NOISE,
        MIX_DRY_COPY
    } traffic_mix_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    sgcj_item_t       item;
    logic             job_valid;
    logic             job_ready;
    sgcj_job_t        job;
    logic             header_we;
    logic [HDR_W-1:0] header_wdata;

    sgcj_job_board    board;
    bit               item_calm = 1'b0;
    bit               job_calm  = 1'b0;
    int unsigned      n_headers = 1;

    scatter_gather_copy_job_merge i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job),
        .header_we    (header_we),
        .header_wdata (header_wdata)
    );

    always #4 clk = ~clk;

    // Sample both handshakes at the edge: all drivers use nonblocking
    // assignments, so values read here are the ones the block saw.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                board.note_item(item);
            if (job_valid && job_ready)
                board.check_job(job);
        end
    end

    // Job sink: draw a stall before each job, hold ready until one is taken.
    // Now and then flip to a calm stretch with ready held high.
    initial
    begin : job_sink
        int unsigned stall;
        job_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                job_calm = !job_calm;
            stall = job_calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                job_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            job_ready <= 1'b1;
            do @(posedge clk); while (!job_valid);
        end
    end

    // Drive one item: idle for a drawn gap, then hold valid and payload until
    // the item is taken. With no gap, valid stays high into the next item.
    task automatic send(input logic op, input logic [ADDR_W-1:0] addr,
                        input logic [LEN_W-1:0] len, input logic end_mark,
                        input logic first);
        sgcj_item_t  it;
        int unsigned gap;
        it.operation         = op;
        it.address           = addr;
        it.length            = len;
        it.end_of_descriptor = end_mark;
        it.first_of_packet   = first;
        if ($urandom_range(0, 39) == 0)
            item_calm = !item_calm;
        gap = item_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
    endtask

    // Drop valid, wait for every predicted job, then give the block time to
    // finish a trailing queue item before anything touches the register.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (board.waiting() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_header(input logic [HDR_W-1:0] value);
        header_wdata <= value;
        header_we    <= 1'b1;
        @(posedge clk);
        board.set_header(value);
        header_we    <= 1'b0;
        n_headers++;
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Mostly short lengths, with zero, the maximum and full-range values mixed in.
    function automatic logic [LEN_W-1:0] rand_len(input int unsigned typical_max);
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)
            return '0;
        if (pick == 2)
            return 16'hFFFF;
        if (pick < 5)
            return LEN_W'($urandom_range(0, 65535));
        return LEN_W'($urandom_range(1, typical_max));
    endfunction

    function automatic traffic_mix_t pick_mix();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return MIX_PACKET;
        if (roll < 70)
            return MIX_JOB_LIMIT;
        if (roll < 80)
            return MIX_QUEUE_BURST;
        if (roll < 90)
            return MIX_NOISE;
        return MIX_DRY_COPY;
    endfunction

    // Directed opening, header at its reset value of 12.
    task automatic run_directed();
        // empty queue: overrun with saturated length, source wraps below zero
        send(OP_COPY, 64'h0, 16'hFFFF, 1'b1, 1'b1);
        send(OP_COPY, '1, 16'h0000, 1'b0, 1'b0);
        // fill the queue; the seventeenth buffer finds it full and is dropped
        for (int i = 0; i < DEST_DEPTH + 1; i++)
        begin
            if (i == 0)
                send(OP_QUEUE, 64'h0, 16'h0000, 1'b0, 1'b1);
            else if (i == 1)
                send(OP_QUEUE, 64'hFFFF_FFFF_FFFF_FF00, 16'hFFFF, 1'b1, 1'b0);
            else
                send(OP_QUEUE, rand_addr(), LEN_W'($urandom_range(1, 40)), (i % 5) == 4,
                     1'b0);
        end
        // zero-length buffer at the head, then the header lands in the big buffer
        send(OP_COPY, 64'h8000_0000_0000_0000, 16'd100, 1'b0, 1'b1);
        // zero-length segment into the partly used head buffer
        send(OP_COPY, 64'h0000_0000_0000_1000, 16'h0000, 1'b1, 1'b0);
        // new packet drops the rest of the open descriptor
        send(OP_COPY, 64'h0000_0000_0001_0000, 16'd5, 1'b0, 1'b1);
        // long segment walks the remaining buffers and runs dry
        send(OP_COPY, 64'h7FFF_FFFF_FFFF_FFF0, 16'hFFFF, 1'b0, 1'b0);
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned  target;
        int unsigned  count;
        traffic_mix_t mix;
        target = board.n_counted + n_items;
        while (board.n_counted < target)
        begin
            mix = pick_mix();
            case (mix)
                MIX_PACKET:
                begin
                    count = $urandom_range(1, 4);
                    for (int i = 0; i < count; i++)
                        send(OP_QUEUE, rand_addr(), rand_len(400), i == count - 1,
                             rand_bit());
                    send(OP_COPY, rand_addr(), rand_len(300), rand_bit(), 1'b1);
                    count = $urandom_range(0, 3);
                    for (int i = 0; i < count; i++)
                        send(OP_COPY, rand_addr(), rand_len(300), rand_bit(), 1'b0);
                end
                MIX_JOB_LIMIT:
                begin
                    count = $urandom_range(10, DEST_DEPTH);
                    for (int i = 0; i < count; i++)
                        send(OP_QUEUE, rand_addr(), LEN_W'($urandom_range(0, 8)),
                             $urandom_range(0, 7) == 0, rand_bit());
                    send(OP_COPY, rand_addr(), LEN_W'($urandom_range(100, 2000)),
                         rand_bit(), rand_bit());
                end
                MIX_QUEUE_BURST:
                begin
                    count = $urandom_range(3, 8);
                    for (int i = 0; i < count; i++)
                        send(OP_QUEUE, rand_addr(), rand_len(400), rand_bit(), rand_bit());
                end
                MIX_NOISE:
                    send(rand_bit(), rand_addr(), LEN_W'($urandom_range(0, 65535)),
                         rand_bit(), rand_bit());
                default:
                    send(OP_COPY, rand_addr(), rand_len(300), rand_bit(), rand_bit());
            endcase
        end
    endtask

    initial
    begin : stimulus
        logic [HDR_W-1:0] settings[6];
        settings[0] = '0;
        settings[1] = 7'h7F;            // saturates to 64
        settings[2] = 7'd65;            // just above the maximum
        settings[3] = HDR_W'(HDR_MAX);
        settings[4] = HDR_W'($urandom_range(0, 127));
        settings[5] = 7'd1;

        board        = new();
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        header_we    <= 1'b0;
        header_wdata <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(30);
        settle();

        // step through header settings, each followed by random traffic
        foreach (settings[k])
        begin
            write_header(settings[k]);
            run_random(58);
            settle();
        end

        $display("covered %0d items: %0d queued buffers (%0d refused on a full queue),",
                 board.n_counted, board.n_queued, board.n_full_drops);
        $display("%0d segments, %0d header settings, %0d jobs (%0d overrun), %0d mismatches",
                 board.n_segments, n_headers, board.n_jobs, board.n_overruns,
                 board.errors);
        if (board.errors == 0 && board.waiting() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #5_000_000;
        $display("timeout with %0d jobs still expected", board.waiting());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
